// ===== rtl/core/telemetry_frame_receiver_defines.svh =====
// Assertion macros for the telemetry frame receiver.
`ifndef TELEMETRY_FRAME_RECEIVER_DEFINES_SVH
`define TELEMETRY_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TFR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TFR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tfr_pkg.sv =====
// Shared types and constants of the telemetry frame receiver.
package tfr_pkg;

	localparam int BYTE_W     = 8;
	localparam int STATUS_W   = 3;
	localparam int WIDX_W     = 4;
	localparam int WORD_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int MAX_WORDS  = 14;
	localparam int HDR_BYTES  = 4;   // payload words start at frame byte 4
	localparam int MIN_BYTES  = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 1'd1;

	localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hAF;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_SUM   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_HDR   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 3'd4;

	// functions that ask for an acknowledge
	localparam logic [BYTE_W-1:0] FUNC_ACK_A = 8'h10;
	localparam logic [BYTE_W-1:0] FUNC_ACK_B = 8'h11;
	localparam logic [BYTE_W-1:0] FUNC_ACK_C = 8'h12;

	// what the collector knows of the frame so far
	typedef struct packed {
		logic              ovf;
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] b0;
		logic [BYTE_W-1:0] b1;
		logic [BYTE_W-1:0] b2;
		logic [BYTE_W-1:0] b4;
	} frm_info_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RD_HI = 4'b0010,
		S_RD_LO = 4'b0100,
		S_WORD  = 4'b1000
	} seq_state_t;

endpackage

// ===== rtl/core/tfr_if.sv =====
// Channel interfaces: received bytes, results and configuration writes.
interface tfr_rx_if;
	import tfr_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              end_of_frame;
	modport source (output valid, output rx_byte, output end_of_frame, input ready);
	modport sink (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface tfr_res_if;
	import tfr_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [STATUS_W-1:0]      status;
	logic [BYTE_W-1:0]        function_code;
	logic [BYTE_W-1:0]        command_byte;
	logic                     ack_request;
	logic [BYTE_W-1:0]        frame_sum;
	logic [WIDX_W-1:0]        word_index;
	logic signed [WORD_W-1:0] word_value;
	logic                     last;
	modport source (output valid, output kind, output status, output function_code,
		output command_byte, output ack_request, output frame_sum, output word_index,
		output word_value, output last, input ready);
	modport sink (input valid, input kind, input status, input function_code,
		input command_byte, input ack_request, input frame_sum, input word_index,
		input word_value, input last, output ready);
endinterface

interface tfr_cfg_if;
	import tfr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/tfr_store.sv =====
// Frame byte store: one write port, one read port with registered data.
module tfr_store #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [tfr_pkg::BYTE_W-1:0] wr_data,
	input  logic [AW-1:0]             rd_addr,
	output logic [tfr_pkg::BYTE_W-1:0] rd_data
);
	import tfr_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/tfr_collect.sv =====
// Byte collector: count, running sum, overflow, header byte capture, store writes.
module tfr_collect #(
	parameter int MAX_FRAME = 32,
	parameter int AW        = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic                       eof,
	input  logic [tfr_pkg::BYTE_W-1:0] rx_byte,
	output logic [AW-1:0]              count,
	output tfr_pkg::frm_info_t         info,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [tfr_pkg::BYTE_W-1:0] wr_data
);
	import tfr_pkg::*;

	localparam logic [AW-1:0] CNT_LIMIT = AW'(MAX_FRAME - 1);

	logic [AW-1:0]     count_q;
	logic [BYTE_W-1:0] sum_q;
	logic              ovf_q;
	logic [BYTE_W-1:0] b0_q, b1_q, b2_q, b4_q;
	logic              full;

	assign full    = (count_q >= CNT_LIMIT);
	assign wr_en   = take && !eof && !full;
	assign wr_addr = count_q;
	assign wr_data = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			if (eof) begin
				count_q <= '0;
				sum_q   <= '0;
				ovf_q   <= 1'b0;
			end else begin
				sum_q <= sum_q + rx_byte;
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + AW'(1);
				end
			end
		end
	end

	// copies of the bytes the header result needs, so the store port stays free
	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (count_q == AW'(0)) b0_q <= rx_byte;
			if (count_q == AW'(1)) b1_q <= rx_byte;
			if (count_q == AW'(2)) b2_q <= rx_byte;
			if (count_q == AW'(4)) b4_q <= rx_byte;
		end
	end

	assign count     = count_q;
	assign info.ovf  = ovf_q;
	assign info.sum  = sum_q;
	assign info.b0   = b0_q;
	assign info.b1   = b1_q;
	assign info.b2   = b2_q;
	assign info.b4   = b4_q;

endmodule

// ===== rtl/core/telemetry_frame_receiver.sv =====
// Telemetry frame receiver top level: frame judgment and result sequencer.
//
//  channel  dir  transaction                       handshake
//  rx       in   one frame byte + end_of_frame     valid/ready
//  res      out  header result or payload word     valid/ready
//  cfg      in   register index + write data       valid/ready (ready held high)
//
// The end-of-frame byte loads the header result. Each payload word then passes
// through RD_HI, RD_LO and WORD: two reads through the single read port of the
// frame store plus the load of the result register when it is free.
// Reset clears the counters and the sequencer and sets the header registers to
// 0xAA / 0xAF; the frame store is not cleared. rx is ready only while the
// sequencer is idle and the result register is empty or being taken.
`include "telemetry_frame_receiver_defines.svh"

module telemetry_frame_receiver #(
	parameter int MAX_FRAME = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	tfr_rx_if.sink    rx,
	tfr_res_if.source res,
	tfr_cfg_if.sink   cfg
);
	import tfr_pkg::*;

	localparam int AW = $clog2(MAX_FRAME);

	seq_state_t        state_q;
	logic [BYTE_W-1:0] hdr_first_q, hdr_second_q;
	logic [WIDX_W-1:0] widx_q, words_q;
	logic [BYTE_W-1:0] hi_q;

	logic              take, eof_take, out_free, load_res;
	logic [AW-1:0]     count;
	frm_info_t         info;
	logic              wr_en;
	logic [AW-1:0]     wr_addr, rd_addr, base_addr;
	logic [BYTE_W-1:0] wr_data, rd_data;

	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   func, cmd;
	logic [AW-1:0]       n_minus4;
	logic [AW-2:0]       words_raw;
	logic [WIDX_W-1:0]   words;
	logic                ack, word_last;

	// result register
	logic                valid_q;
	logic                kind_q;
	logic [STATUS_W-1:0] status_q;
	logic [BYTE_W-1:0]   func_q, cmd_q, sum_q;
	logic                ack_q;
	logic [WIDX_W-1:0]   index_q;
	logic [WORD_W-1:0]   value_q;
	logic                last_q;

	assign out_free = !valid_q || res.ready;
	assign rx.ready = (state_q == S_IDLE) && out_free;
	assign take     = rx.valid && rx.ready;
	assign eof_take = take && rx.end_of_frame;
	assign load_res = eof_take || (state_q == S_WORD && out_free);
	assign cfg.ready = 1'b1;

	tfr_collect #(.MAX_FRAME(MAX_FRAME), .AW(AW)) u_collect (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.eof     (rx.end_of_frame),
		.rx_byte (rx.rx_byte),
		.count   (count),
		.info    (info),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	tfr_store #(.DEPTH(MAX_FRAME), .AW(AW)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// frame judgment at the checksum byte
	always_comb begin
		if (info.ovf) begin
			status = ST_TOO_LONG;
		end else if (count < AW'(MIN_BYTES)) begin
			status = ST_TOO_SHORT;
		end else if (rx.rx_byte != info.sum) begin
			status = ST_BAD_SUM;
		end else if (info.b0 != hdr_first_q || info.b1 != hdr_second_q) begin
			status = ST_BAD_HDR;
		end else begin
			status = ST_OK;
		end
	end

	assign func = (count > AW'(2)) ? info.b2 : '0;
	assign cmd  = (count > AW'(HDR_BYTES)) ? info.b4 : '0;
	assign ack  = (status == ST_OK) &&
		(func == FUNC_ACK_A || func == FUNC_ACK_B || func == FUNC_ACK_C);

	assign n_minus4  = count - AW'(HDR_BYTES);
	assign words_raw = n_minus4[AW-1:1];
	assign words     = (8'(words_raw) > 8'(MAX_WORDS)) ? WIDX_W'(MAX_WORDS)
		: WIDX_W'(words_raw);

	// high byte of word i sits at 4 + 2i, low byte right after
	assign base_addr = AW'({widx_q, 1'b0} + (WIDX_W + 1)'(HDR_BYTES));
	assign rd_addr   = (state_q == S_RD_HI) ? base_addr : base_addr + AW'(1);
	assign word_last = (widx_q + WIDX_W'(1)) == words_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first_q  <= HEADER_FIRST_RST;
			hdr_second_q <= HEADER_SECOND_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_HEADER_FIRST:  hdr_first_q  <= cfg.data;
				REG_HEADER_SECOND: hdr_second_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
			widx_q  <= '0;
			words_q <= '0;
		end else begin
			valid_q <= load_res || (valid_q && !res.ready);
			case (state_q)
				S_IDLE: begin
					if (eof_take) begin
						widx_q  <= '0;
						words_q <= words;
						if (status == ST_OK && words != '0) begin
							state_q <= S_RD_HI;
						end
					end
				end
				S_RD_HI: state_q <= S_RD_LO;
				S_RD_LO: state_q <= S_WORD;
				S_WORD: begin
					if (out_free) begin
						widx_q  <= widx_q + WIDX_W'(1);
						state_q <= word_last ? S_IDLE : S_RD_HI;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_RD_LO) begin
			hi_q <= rd_data;
		end
		if (eof_take) begin
			kind_q   <= 1'b0;
			status_q <= status;
			func_q   <= func;
			cmd_q    <= cmd;
			ack_q    <= ack;
			sum_q    <= info.sum;
			index_q  <= '0;
			value_q  <= '0;
			last_q   <= (status != ST_OK) || (words == '0);
		end else if (state_q == S_WORD && out_free) begin
			// function, command and sum stay from the header result
			kind_q   <= 1'b1;
			status_q <= ST_OK;
			ack_q    <= 1'b0;
			index_q  <= widx_q;
			value_q  <= {hi_q, rd_data};
			last_q   <= word_last;
		end
	end

	assign res.valid         = valid_q;
	assign res.kind          = kind_q;
	assign res.status        = status_q;
	assign res.function_code = func_q;
	assign res.command_byte  = cmd_q;
	assign res.ack_request   = ack_q;
	assign res.frame_sum     = sum_q;
	assign res.word_index    = index_q;
	assign res.word_value    = signed'(value_q);
	assign res.last          = last_q;

	`TFR_ASSERT_IMP(a_pending_words, res.valid && !res.last, state_q != S_IDLE, "non-last result with idle sequencer")
	`TFR_ASSERT_IMP(a_reject_last, res.valid && !res.kind && res.status != ST_OK, res.last, "rejected frame header not last")
	`TFR_ASSERT_IMP(a_word_fields, res.valid && res.kind, res.status == ST_OK && !res.ack_request, "word result with status or ack")
	`TFR_ASSERT_NXT(a_word_load, state_q == S_WORD && !res.valid, res.valid, "word not loaded into empty result register")

endmodule
